@@ sv/u8esc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8esc_pkg
// Types, codes and helper functions shared by the UTF-8 decoder blocks.
// ----------------------------------------------------------------------------
package u8esc_pkg;

    localparam logic [7:0]  CH_BACKSLASH = 8'h5C;
    localparam logic [7:0]  CH_X         = 8'h58;
    localparam logic [20:0] CP_REPLACE   = 21'h00FFFD;

    typedef enum logic [0:0] {
        FS_IDLE,
        FS_RUN
    } t_fstate;

    typedef enum logic [1:0] {
        ACT_CHAR,
        ACT_ESC,
        ACT_STOP
    } t_act;

    typedef struct packed {
        logic        is_esc;
        logic [20:0] value;
        logic        run_last;
        logic        block_last;
    } t_token;

    typedef struct packed {
        logic   valid;
        t_token token;
    } t_push;

    function automatic logic [2:0] seq_len(input logic [7:0] lead);
        logic [2:0] len;
        len = 3'd0;
        priority if (lead < 8'hC2) begin
            len = 3'd0;
        end else if ((lead & 8'hE0) == 8'hC0) begin
            len = 3'd2;
        end else if ((lead & 8'hF0) == 8'hE0) begin
            len = 3'd3;
        end else if (lead <= 8'hF4) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

    function automatic logic cont_ok(input logic [7:0] lead, input logic second,
                                     input logic [7:0] b);
        logic ok;
        ok = ((b & 8'hC0) == 8'h80);
        if (ok && second) begin
            priority if (lead == 8'hE0) begin
                ok = (b >= 8'hA0);
            end else if (lead == 8'hED) begin
                ok = (b <= 8'h9F);
            end else if (lead == 8'hF0) begin
                ok = (b >= 8'h90);
            end else if (lead == 8'hF4) begin
                ok = (b <= 8'h8F);
            end else begin
                ok = 1'b1;
            end
        end
        return ok;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10) begin
            c = 8'h30 + {4'h0, v};
        end else begin
            c = 8'h41 + {4'h0, v} - 8'd10;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ sv/u8esc_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8esc_fifo
// Short token queue between the classifier and the character expander.
// ----------------------------------------------------------------------------
module u8esc_fifo
    import u8esc_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_push  i_push,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_valid,
    output t_token      o_token
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_token        r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_do_push;
    logic          w_do_pop;

    assign o_full    = (r_cnt == FULL_CNT);
    assign o_valid   = (r_cnt != '0);
    assign o_token   = r_mem[r_rd];
    assign w_do_push = i_push.valid && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            unique case ({w_do_push, w_do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_push.token;
        end
    end

endmodule
`default_nettype wire

@@ sv/u8esc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8esc_front
// Accept bytes, hold incomplete sequences, classify into char/escape tokens.
// ----------------------------------------------------------------------------
module u8esc_front
    import u8esc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic       i_s_axis_tlast,   // end_of_data
    output t_push           o_push,
    input  wire logic       i_full
);

    t_fstate    r_state, n_state;
    logic [7:0] r_q [4];
    logic [7:0] n_q [4];
    logic [2:0] r_n, n_n;
    logic       r_eod, n_eod;
    logic       r_hv, n_hv;
    t_token     r_hold, n_hold;

    t_act        w_act;
    logic [2:0]  w_shift;
    logic [7:0]  w_lead;
    logic [2:0]  w_len;
    logic [2:0]  w_avail;
    logic        w_ok;
    logic [20:0] w_cp;

    assign w_lead  = r_q[0];
    assign w_len   = seq_len(w_lead);
    assign w_avail = (r_n < w_len) ? r_n : w_len;
    assign w_ok    = ((w_avail <= 3'd1) || cont_ok(w_lead, 1'b1, r_q[1]))
                  && ((w_avail <= 3'd2) || cont_ok(w_lead, 1'b0, r_q[2]))
                  && ((w_avail <= 3'd3) || cont_ok(w_lead, 1'b0, r_q[3]));

    always_comb begin
        unique case (w_len)
            3'd2:    w_cp = {10'b0, w_lead[4:0], r_q[1][5:0]};
            3'd3:    w_cp = {5'b0, w_lead[3:0], r_q[1][5:0], r_q[2][5:0]};
            3'd4:    w_cp = {w_lead[2:0], r_q[1][5:0], r_q[2][5:0], r_q[3][5:0]};
            default: w_cp = {13'b0, w_lead};
        endcase
    end

    always_comb begin
        w_act   = ACT_STOP;
        w_shift = 3'd1;
        priority if (r_n == 3'd0) begin
            w_act = ACT_STOP;
        end else if (w_lead < 8'h80) begin
            w_act = ACT_CHAR;
        end else if (w_len == 3'd0) begin
            w_act = ACT_ESC;
        end else if (w_ok && (w_avail == w_len) && (w_cp != CP_REPLACE)) begin
            w_act   = ACT_CHAR;
            w_shift = w_len;
        end else if (w_ok && (w_avail != w_len) && !r_eod) begin
            w_act = ACT_STOP;
        end else begin
            w_act = ACT_ESC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_n     <= '0;
            r_eod   <= 1'b0;
            r_hv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_eod   <= n_eod;
            r_hv    <= n_hv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q    <= n_q;
        r_hold <= n_hold;
    end

    always_comb begin
        n_state         = r_state;
        n_q             = r_q;
        n_n             = r_n;
        n_eod           = r_eod;
        n_hv            = r_hv;
        n_hold          = r_hold;
        o_s_axis_tready = 1'b0;
        o_push.valid    = 1'b0;
        o_push.token    = r_hold;
        unique case (r_state)
            FS_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_q[r_n[1:0]] = i_s_axis_tdata;
                    n_n           = r_n + 3'd1;
                    n_eod         = i_s_axis_tlast;
                    n_state       = FS_RUN;
                end
            end
            FS_RUN: begin
                if (w_act == ACT_STOP) begin
                    // flush the held token with the end-of-run marks
                    o_push.token.run_last   = 1'b1;
                    o_push.token.block_last = r_eod;
                    if (!r_hv) begin
                        n_state = FS_IDLE;
                    end else if (!i_full) begin
                        o_push.valid = 1'b1;
                        n_hv         = 1'b0;
                        n_state      = FS_IDLE;
                    end
                end else if (!r_hv || !i_full) begin
                    o_push.valid      = r_hv;
                    n_hv              = 1'b1;
                    n_hold.is_esc     = (w_act == ACT_ESC);
                    n_hold.value      = (w_act == ACT_ESC) ? {13'b0, w_lead} : w_cp;
                    n_hold.run_last   = 1'b0;
                    n_hold.block_last = 1'b0;
                    n_n               = r_n - w_shift;
                    for (int i = 0; i < 4; i++) begin
                        logic [2:0] j;
                        j = 3'(i) + w_shift;
                        n_q[i] = (j < 3'd4) ? r_q[j[1:0]] : 8'h00;
                    end
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ sv/u8esc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8esc_back
// Expand tokens into output words: one code point or a four-character escape.
// ----------------------------------------------------------------------------
module u8esc_back
    import u8esc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_token      i_token,
    output logic             o_pop,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,  // [20:0] code_point
    output logic             o_m_axis_tlast,  // run_last
    output logic [0:0]       o_m_axis_tuser   // [0] block_last
);

    logic       r_valid, n_valid;
    t_token     r_tok, n_tok;
    logic [1:0] r_idx, n_idx;

    logic        w_final;
    logic        w_take;
    logic        w_load;
    logic [7:0]  w_esc_ch;
    logic [20:0] w_cp;

    assign w_final = !r_tok.is_esc || (r_idx == 2'd3);
    assign w_take  = r_valid && i_m_axis_tready;
    assign w_load  = !r_valid || (w_take && w_final);
    assign o_pop   = w_load && i_valid;

    always_comb begin
        unique case (r_idx)
            2'd0: w_esc_ch = CH_BACKSLASH;
            2'd1: w_esc_ch = CH_X;
            2'd2: w_esc_ch = hex_digit(r_tok.value[7:4]);
            2'd3: w_esc_ch = hex_digit(r_tok.value[3:0]);
        endcase
    end

    assign w_cp            = r_tok.is_esc ? {13'b0, w_esc_ch} : r_tok.value;
    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {3'b0, w_cp};
    assign o_m_axis_tlast  = w_final && r_tok.run_last;
    assign o_m_axis_tuser  = w_final && r_tok.block_last;

    always_comb begin
        n_valid = r_valid;
        n_tok   = r_tok;
        n_idx   = r_idx;
        if (w_load) begin
            n_valid = i_valid;
            n_tok   = i_token;
            n_idx   = 2'd0;
        end else if (w_take) begin
            n_idx = r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

endmodule
`default_nettype wire

@@ sv/utf8_decode_with_byte_escape_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_decode_with_byte_escape_unit
// Stream UTF-8 decoder that escapes rejected lead bytes as \XHH.
// ----------------------------------------------------------------------------
// Bytes enter on the slave stream with tlast marking end of data; code points
// leave on the master stream, tlast on the last word caused by a byte and
// tuser[0] on the last word of the data block. The front classifier accepts a
// byte only while idle, then produces its tokens (a code point or an escape)
// one at a time and closes with a step that flushes any held token, marked as
// the end of the run; it takes no new byte before that. The back expander
// writes one word per cycle while the output is ready, and an escaped byte
// expands to a four-character escape; the sustained rate is set by whichever
// side is slower. A token queue of FIFO_DEPTH entries lets the two sides stall
// independently.
// ----------------------------------------------------------------------------
module utf8_decode_with_byte_escape_unit
    import u8esc_pkg::*;
#(
    parameter int FIFO_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,  // [7:0] data_byte
    input  wire logic        i_s_axis_tlast,  // end_of_data
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,  // [20:0] code_point
    output logic             o_m_axis_tlast,  // run_last
    output logic [0:0]       o_m_axis_tuser   // [0] block_last
);

    t_push  w_push;
    logic   w_full;
    logic   w_pop;
    logic   w_fifo_valid;
    t_token w_fifo_tok;

    u8esc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_push          (w_push),
        .i_full          (w_full)
    );

    u8esc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_fifo_valid),
        .o_token (w_fifo_tok)
    );

    u8esc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_fifo_valid),
        .i_token         (w_fifo_tok),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> !w_full)
        else $error("token pushed into full queue");

    a_block_implies_run : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> o_m_axis_tlast)
        else $error("block end without run end");

    a_scalar_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tdata[20:0] <= 21'h10FFFF)
                          && (o_m_axis_tdata[20:0] != CP_REPLACE)
                          && (o_m_axis_tdata[20:11] != 10'b0000011011)))
        else $error("emitted code point is not a permitted scalar");

endmodule
`default_nettype wire
